FILE: rtl/tfr_pkg.sv
// telemetry frame receiver package: shared constants, types and the crc-8 step
// no dependencies

package tfr_pkg;

  localparam int FRAME_DEPTH_DEF    = 64;
  localparam int ACCEPT_ENTRIES_DEF = 6;
  localparam int MAX_ENTRIES        = 6;
  localparam int LEN_LIMIT          = 62;
  localparam int CNT_W              = 6;
  localparam int CFG_IDX_W          = 4;
  localparam int CFG_DATA_W         = 16;

  localparam logic [7:0] SYNC_RESET = 8'hEA;
  localparam logic [7:0] POLY_RESET = 8'hD5;
  localparam logic [15:0] ENTRY_RESET [MAX_ENTRIES] = '{
    16'h0211, 16'h0704, 16'h080A, 16'h1E08, 16'h140C, 16'h3A0D
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC    = 4'd0,
    REG_POLY    = 4'd1,
    REG_ENTRY_0 = 4'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_TYPE,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  typedef enum logic {
    EM_IDLE,
    EM_RUN
  } emit_state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] total;
    logic [7:0]       ftype;
  } emit_req_t;

  // msb-first crc-8 over one byte
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data,
                                           logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ poly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

FILE: rtl/tfr_rx_if.sv
// received byte channel: valid/ready with one link byte and a clear flag
// no dependencies

interface tfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       clear_parser;

  modport source (output valid, output rx_byte, output clear_parser, input ready);
  modport sink   (input valid, input rx_byte, input clear_parser, output ready);
endinterface

FILE: rtl/tfr_frame_if.sv
// frame byte channel: valid/ready with one emitted frame byte and its position
// depends on tfr_pkg

interface tfr_frame_if import tfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       frame_byte;
  logic [CNT_W-1:0] byte_index;
  logic [7:0]       frame_type;
  logic             last_byte;

  modport source (output valid, output frame_byte, output byte_index,
                  output frame_type, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input byte_index,
                  input frame_type, input last_byte, output ready);
endinterface

FILE: rtl/tfr_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module tfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tfr_parser.sv
// byte parser: config registers, sync/length/type checks, crc and frame buffer writes
// depends on tfr_pkg, tfr_rx_if

module tfr_parser import tfr_pkg::*; #(
  parameter int FRAME_DEPTH    = FRAME_DEPTH_DEF,
  parameter int ACCEPT_ENTRIES = ACCEPT_ENTRIES_DEF,
  localparam int AW            = $clog2(FRAME_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tfr_rx_if.sink                rx,
  input  logic                  emit_busy,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [7:0]            wr_data,
  output emit_req_t             emit_req
);

  logic [7:0]  sync_r;
  logic [7:0]  poly_r;
  logic [15:0] entry_r [ACCEPT_ENTRIES];

  phase_t           phase_r, phase_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       crc_r, crc_nxt;

  // type byte sits at entry 0 of the buffer, kept here too for the emitter
  logic [7:0]       type_r;

  logic             accept;
  logic             len_ok;
  logic             hit;
  logic [7:0]       crc_base;
  logic [7:0]       crc_new;
  logic [CNT_W-1:0] cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
      poly_r <= POLY_RESET;
      for (int i = 0; i < ACCEPT_ENTRIES; i++) begin
        entry_r[i] <= ENTRY_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_SYNC) begin
        sync_r <= cfg_wdata[7:0];
      end
      if (cfg_index == REG_POLY) begin
        poly_r <= cfg_wdata[7:0];
      end
      for (int i = 0; i < ACCEPT_ENTRIES; i++) begin
        if (cfg_index == CFG_IDX_W'(int'(REG_ENTRY_0) + i)) begin
          entry_r[i] <= cfg_wdata;
        end
      end
    end
  end

  assign rx.ready = !emit_busy;
  assign accept   = rx.valid && rx.ready;

  assign len_ok = (len_r >= 8'd2) && (len_r <= 8'(LEN_LIMIT)) &&
                  ({1'b0, len_r} <= 9'(FRAME_DEPTH + 1));

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < ACCEPT_ENTRIES; i++) begin
      if (entry_r[i] == {rx.rx_byte, len_r}) begin
        hit = 1'b1;
      end
    end
  end

  assign crc_base = (phase_r == PH_TYPE) ? 8'd0 : crc_r;
  assign crc_new  = crc8_step(crc_base, rx.rx_byte, poly_r);
  assign cnt_inc  = cnt_r + CNT_W'(1);

  always_comb begin
    phase_nxt      = phase_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    crc_nxt        = crc_r;
    wr_en          = 1'b0;
    wr_addr        = AW'(cnt_r);
    wr_data        = rx.rx_byte;
    emit_req       = '0;
    emit_req.ftype = type_r;
    if (accept) begin
      if (rx.clear_parser) begin
        phase_nxt = PH_IDLE;
        len_nxt   = '0;
        cnt_nxt   = '0;
        crc_nxt   = '0;
      end else begin
        unique case (phase_r)
          PH_LEN: begin
            len_nxt   = rx.rx_byte;
            phase_nxt = PH_TYPE;
          end
          PH_TYPE: begin
            if (len_ok && hit) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              cnt_nxt   = CNT_W'(1);
              crc_nxt   = crc_new;
              phase_nxt = (len_r <= 8'd2) ? PH_CRC : PH_PAYLOAD;
            end else begin
              phase_nxt = PH_IDLE;
              len_nxt   = '0;
              cnt_nxt   = '0;
              crc_nxt   = '0;
            end
          end
          PH_PAYLOAD: begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_inc;
            crc_nxt = crc_new;
            if ((8'(cnt_inc) + 8'd1) >= len_r) begin
              phase_nxt = PH_CRC;
            end
          end
          PH_CRC: begin
            if (rx.rx_byte == crc_r) begin
              emit_req.start = 1'b1;
            end
            emit_req.total = cnt_r;
            phase_nxt      = PH_IDLE;
            len_nxt        = '0;
            cnt_nxt        = '0;
            crc_nxt        = '0;
          end
          default: begin
            if (rx.rx_byte == sync_r) begin
              phase_nxt = PH_LEN;
              len_nxt   = '0;
              cnt_nxt   = '0;
              crc_nxt   = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !rx.clear_parser && phase_r == PH_TYPE) begin
      type_r <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
      crc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

FILE: rtl/tfr_emit.sv
// frame emitter: sweeps the frame buffer through its read port into the output register
// depends on tfr_pkg, tfr_frame_if

module tfr_emit import tfr_pkg::*; #(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF,
  localparam int AW         = $clog2(FRAME_DEPTH)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  emit_req_t   emit_req,
  output logic        emit_busy,
  output logic        rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]  rd_data,
  tfr_frame_if.source out
);

  emit_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [7:0]       type_r, type_nxt;

  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic [CNT_W-1:0] oi_r, oi_nxt;
  logic [7:0]       ot_r, ot_nxt;
  logic             ol_r, ol_nxt;

  logic slot_free;
  logic load;
  logic issue;

  assign slot_free = !ov_r || out.ready;
  assign load      = pend_r && slot_free;
  assign issue     = (state_r == EM_RUN) && (rd_idx_r != total_r) && (!pend_r || load);

  assign rd_en     = issue;
  assign rd_addr   = AW'(rd_idx_r);
  assign emit_busy = (state_r == EM_RUN);

  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    total_nxt    = total_r;
    type_nxt     = type_r;
    pend_idx_nxt = issue ? rd_idx_r : pend_idx_r;
    pend_nxt     = issue ? 1'b1 : (load ? 1'b0 : pend_r);
    unique case (state_r)
      EM_IDLE: begin
        if (emit_req.start) begin
          state_nxt  = EM_RUN;
          rd_idx_nxt = '0;
          total_nxt  = emit_req.total;
          type_nxt   = emit_req.ftype;
        end
      end
      EM_RUN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (rd_idx_nxt == total_r && !pend_nxt) begin
          state_nxt = EM_IDLE;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase

    ov_nxt = ov_r;
    ob_nxt = ob_r;
    oi_nxt = oi_r;
    ot_nxt = ot_r;
    ol_nxt = ol_r;
    if (load) begin
      ov_nxt = 1'b1;
      ob_nxt = rd_data;
      oi_nxt = pend_idx_r;
      ot_nxt = type_r;
      ol_nxt = (pend_idx_r + CNT_W'(1)) == total_r;
    end else if (out.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    total_r    <= total_nxt;
    type_r     <= type_nxt;
    ob_r       <= ob_nxt;
    oi_r       <= oi_nxt;
    ot_r       <= ot_nxt;
    ol_r       <= ol_nxt;
  end

  assign out.valid      = ov_r;
  assign out.frame_byte = ob_r;
  assign out.byte_index = oi_r;
  assign out.frame_type = ot_r;
  assign out.last_byte  = ol_r;

endmodule

FILE: rtl/telemetry_frame_receiver_core.sv
// telemetry frame receiver top level: parser, frame buffer ram and emitter
// depends on tfr_pkg, tfr_rx_if, tfr_frame_if, tfr_ram, tfr_parser, tfr_emit
//
// usage
//   in_rx carries one link byte per transaction; clear_parser drops the byte
//   and returns the parser to idle. out_frame carries the type byte and the
//   payload bytes of each frame whose crc-8 checks, index 0 first, last_byte
//   on the final one. cfg_we/cfg_index/cfg_wdata write the sync byte,
//   the crc polynomial and the accept table; write only while idle.
//   a byte is taken every cycle while no frame is being emitted. the
//   transaction that carries a good crc byte starts a sweep of the frame
//   buffer through its single read port, one byte per cycle while out_frame
//   is not stalled, and in_rx.ready stays low during the sweep; each byte
//   passes the run state, the registered ram read and the output register.
//   a stalled out_frame holds its byte and the sweep waits, which keeps
//   in_rx.ready low until the last byte sits in the output register.
//   reset restores the register defaults and leaves the parser idle; the
//   buffer needs no clearing since only bytes of the current frame are read.

module telemetry_frame_receiver_core import tfr_pkg::*; #(
  parameter int FRAME_DEPTH    = FRAME_DEPTH_DEF,
  parameter int ACCEPT_ENTRIES = ACCEPT_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tfr_rx_if.sink                in_rx,
  tfr_frame_if.source           out_frame
);

  localparam int AW = $clog2(FRAME_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  emit_req_t     emit_req;
  logic          emit_busy;

  tfr_parser #(
    .FRAME_DEPTH    (FRAME_DEPTH),
    .ACCEPT_ENTRIES (ACCEPT_ENTRIES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rx        (in_rx),
    .emit_busy (emit_busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .emit_req  (emit_req)
  );

  tfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tfr_emit #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_req  (emit_req),
    .emit_busy (emit_busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out       (out_frame)
  );

endmodule

FILE: rtl/tfr_checker.sv
// port-level checks for the telemetry frame receiver, bound to the top level
// depends on tfr_pkg, telemetry_frame_receiver_core

module tfr_checker import tfr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [7:0]       out_frame_byte,
  input logic [CNT_W-1:0] out_byte_index,
  input logic [7:0]       out_frame_type,
  input logic             out_last_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_frame_byte, out_byte_index, out_frame_type, out_last_byte}))
    else $error("stalled output transaction changed");

  a_type_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_index == '0 |-> out_frame_byte == out_frame_type)
    else $error("index zero byte differs from frame type");

  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input stalled without a preceding input transaction");

endmodule

bind telemetry_frame_receiver_core tfr_checker u_tfr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_rx.valid),
  .in_ready       (in_rx.ready),
  .out_valid      (out_frame.valid),
  .out_ready      (out_frame.ready),
  .out_frame_byte (out_frame.frame_byte),
  .out_byte_index (out_frame.byte_index),
  .out_frame_type (out_frame.frame_type),
  .out_last_byte  (out_frame.last_byte)
);
